// ===== design/wcs_pkg.sv =====
package wcs_pkg;

    localparam int unsigned CYCLE_W  = 4;
    localparam int unsigned VOL_W    = 24;
    localparam int unsigned MINUTE_W = 11;
    localparam int unsigned SECS_W   = 32;
    localparam int unsigned CFG_W    = 49;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CYCLE_W-1:0] MANUAL_CYCLE = 4'd8;
    localparam logic [VOL_W-1:0]   VOL_MAX      = 24'hFF_FFFF;

    // Request codes
    localparam logic [2:0] REQ_TICK   = 3'd0;
    localparam logic [2:0] REQ_MANUAL = 3'd1;
    localparam logic [2:0] REQ_STOP   = 3'd2;
    localparam logic [2:0] REQ_PAUSE  = 3'd3;
    localparam logic [2:0] REQ_RESUME = 3'd4;

    // Slot completion modes
    localparam logic [1:0] MODE_VOLUME  = 2'd0;
    localparam logic [1:0] MODE_END     = 2'd1;
    localparam logic [1:0] MODE_EITHER  = 2'd2;
    localparam logic [1:0] MODE_NO_AUTO = 2'd3;

    // Stop reasons
    localparam logic REASON_COMPLETED = 1'b0;
    localparam logic REASON_USER      = 1'b1;

    typedef struct packed {
        logic [VOL_W-1:0]    target_ml;
        logic [MINUTE_W-1:0] end_minute;
        logic [MINUTE_W-1:0] start_minute;
        logic [1:0]          mode;
        logic                enable;
    } slot_t;

    typedef struct packed {
        logic [2:0]          req_type;
        logic                clock_valid;
        logic [MINUTE_W-1:0] minute_of_day;
        logic [SECS_W-1:0]   now_seconds;
        logic [15:0]         flow_delta_ml;
        logic [VOL_W-1:0]    manual_target_ml;
    } in_t;

    typedef struct packed {
        logic               valve_on;
        logic               run_active;
        logic               run_paused;
        logic [CYCLE_W-1:0] current_cycle;
        logic               stop_event;
        logic               stop_reason;
        logic [CYCLE_W-1:0] stopped_cycle;
        logic [VOL_W-1:0]   stopped_volume_ml;
        logic [15:0]        run_seconds;
    } out_t;

    // Slot evaluation results handed to the sequencing logic
    typedef struct packed {
        logic               start_hit;
        logic [CYCLE_W-1:0] start_slot;
        logic               start_done;
        logic               run_done;
    } sched_t;

endpackage

// ===== design/wcs_slot_eval.sv =====
module wcs_slot_eval #(
    parameter int unsigned NUM_SLOTS = 8
) (
    input  wcs_pkg::slot_t                     slots [NUM_SLOTS],
    input  logic [wcs_pkg::MINUTE_W-1:0]       minute,
    input  logic [wcs_pkg::CYCLE_W-1:0]        cycle_select,
    input  logic [wcs_pkg::VOL_W-1:0]          delivered_ml,
    input  logic [wcs_pkg::VOL_W-1:0]          manual_goal_ml,
    output wcs_pkg::sched_t                    sched
);

    localparam int unsigned SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [wcs_pkg::CYCLE_W:0] SLOT_COUNT = (wcs_pkg::CYCLE_W + 1)'(NUM_SLOTS);

    function automatic logic mode_done(
        input wcs_pkg::slot_t                s,
        input logic [wcs_pkg::VOL_W-1:0]     vol,
        input logic [wcs_pkg::MINUTE_W-1:0]  min_now
    );
        logic vol_hit;
        logic time_hit;
        logic done;
        vol_hit  = (vol >= s.target_ml);
        time_hit = (min_now >= s.end_minute);
        case (s.mode)
            wcs_pkg::MODE_VOLUME:  done = vol_hit;
            wcs_pkg::MODE_END:     done = time_hit;
            wcs_pkg::MODE_EITHER:  done = vol_hit || time_hit;
            wcs_pkg::MODE_NO_AUTO: done = 1'b0;
            default:               done = 1'b0;
        endcase
        return done;
    endfunction

    always_comb
    begin
        // Lowest enabled slot matching the current minute; a fresh run has zero volume
        sched.start_hit  = 1'b0;
        sched.start_slot = '0;
        sched.start_done = 1'b0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (slots[i].enable && (slots[i].start_minute == minute))
            begin
                sched.start_hit  = 1'b1;
                sched.start_slot = wcs_pkg::CYCLE_W'(i);
                sched.start_done = mode_done(slots[i], '0, minute);
            end
        end

        // Completion of the run already in progress
        if (cycle_select == wcs_pkg::MANUAL_CYCLE)
        begin
            sched.run_done = (manual_goal_ml != '0) && (delivered_ml >= manual_goal_ml);
        end
        else if ({1'b0, cycle_select} < SLOT_COUNT)
        begin
            sched.run_done = mode_done(slots[cycle_select[SLOT_IDX_W-1:0]],
                                       delivered_ml, minute);
        end
        else
        begin
            sched.run_done = 1'b0;
        end
    end

endmodule

// ===== design/watering_cycle_scheduler.sv =====
// Path: an accepted item waits in the input register; the state update and the result
// register load together in one pass, and the result register drives out_valid.
// Throughput: one item per cycle while out_stall is low; the input register takes one
// more item while a finished result waits under out_stall, then in_stall rises.
// Reset (rst_n low, asynchronous): run state, valid flags and slot registers clear;
// every slot comes up disabled.
module watering_cycle_scheduler #(
    parameter int unsigned NUM_SLOTS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // item input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  wcs_pkg::in_t                      in_data,
    // result output channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output wcs_pkg::out_t                     out_data,
    // slot register writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [wcs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wcs_pkg::CFG_W-1:0]         cfg_data
);

    localparam int unsigned SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [wcs_pkg::CFG_IDX_W:0] SLOT_COUNT =
        (wcs_pkg::CFG_IDX_W + 1)'(NUM_SLOTS);
    localparam logic [wcs_pkg::CYCLE_W:0] SLOT_LIMIT = (wcs_pkg::CYCLE_W + 1)'(NUM_SLOTS);

    // ------------------------------------------------------------------
    // Slot registers. Indexes beyond the configured slot count are dropped.
    // ------------------------------------------------------------------
    wcs_pkg::slot_t slot_reg [NUM_SLOTS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready && ({1'b0, cfg_index} < SLOT_COUNT))
        begin
            slot_reg[cfg_index[SLOT_IDX_W-1:0]] <= wcs_pkg::slot_t'(cfg_data);
        end
    end

    // ------------------------------------------------------------------
    // Handshake: input register feeds the single processing pass, which
    // writes the result register. Advance whenever the result register is
    // free or being drained this cycle.
    // ------------------------------------------------------------------
    logic          in_vld_reg;
    logic          in_vld_next;
    wcs_pkg::in_t  in_reg;
    logic          out_vld_reg;
    logic          out_vld_next;
    wcs_pkg::out_t out_reg;
    wcs_pkg::out_t out_next;
    logic          advance;
    logic          fire;
    logic          in_take;

    assign advance  = !out_vld_reg || !out_stall;
    assign fire     = in_vld_reg && advance;
    assign in_stall = in_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    assign in_vld_next  = in_take || (in_vld_reg && !advance);
    assign out_vld_next = fire || (out_vld_reg && out_stall);

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    // ------------------------------------------------------------------
    // Run state
    // ------------------------------------------------------------------
    logic                             active_reg;
    logic                             active_next;
    logic                             paused_reg;
    logic                             paused_next;
    logic [wcs_pkg::CYCLE_W-1:0]      cycle_reg;
    logic [wcs_pkg::CYCLE_W-1:0]      cycle_next;
    logic [wcs_pkg::VOL_W-1:0]        delivered_reg;
    logic [wcs_pkg::VOL_W-1:0]        delivered_next;
    logic [wcs_pkg::SECS_W-1:0]       start_reg;
    logic [wcs_pkg::SECS_W-1:0]       start_next;
    logic [wcs_pkg::VOL_W-1:0]        goal_reg;
    logic [wcs_pkg::VOL_W-1:0]        goal_next;

    // Flow accumulates first, saturating, only while the valve is open
    logic [wcs_pkg::VOL_W:0]          vol_sum;
    logic [wcs_pkg::VOL_W-1:0]        vol_acc;
    logic [wcs_pkg::SECS_W-1:0]       elapsed;
    wcs_pkg::sched_t                  sched;

    assign vol_sum = {1'b0, delivered_reg} + (wcs_pkg::VOL_W + 1)'(in_reg.flow_delta_ml);
    assign vol_acc = (active_reg && !paused_reg)
                   ? (vol_sum[wcs_pkg::VOL_W] ? wcs_pkg::VOL_MAX : vol_sum[wcs_pkg::VOL_W-1:0])
                   : delivered_reg;
    assign elapsed = in_reg.now_seconds - start_reg;

    wcs_slot_eval #(
        .NUM_SLOTS      (NUM_SLOTS)
    ) u_slot_eval (
        .slots          (slot_reg),
        .minute         (in_reg.minute_of_day),
        .cycle_select   (cycle_reg),
        .delivered_ml   (vol_acc),
        .manual_goal_ml (goal_reg),
        .sched          (sched)
    );

    always_comb
    begin
        active_next    = active_reg;
        paused_next    = paused_reg;
        cycle_next     = cycle_reg;
        delivered_next = vol_acc;
        start_next     = start_reg;
        goal_next      = goal_reg;

        out_next                   = '0;
        out_next.stop_reason       = wcs_pkg::REASON_COMPLETED;

        case (in_reg.req_type)
            wcs_pkg::REQ_TICK:
            begin
                if (!active_reg && in_reg.clock_valid && sched.start_hit)
                begin
                    if (sched.start_done)
                    begin
                        // started and finished on the same tick: report, stay idle
                        out_next.stop_event    = 1'b1;
                        out_next.stopped_cycle = sched.start_slot;
                        delivered_next         = '0;
                    end
                    else
                    begin
                        active_next    = 1'b1;
                        paused_next    = 1'b0;
                        cycle_next     = sched.start_slot;
                        delivered_next = '0;
                        start_next     = in_reg.now_seconds;
                        goal_next      = '0;
                    end
                end
                else if (active_reg && !paused_reg && sched.run_done)
                begin
                    out_next.stop_event        = 1'b1;
                    out_next.stopped_cycle     = cycle_reg;
                    out_next.stopped_volume_ml = vol_acc;
                    out_next.run_seconds       = elapsed[15:0];
                    active_next    = 1'b0;
                    paused_next    = 1'b0;
                    cycle_next     = '0;
                    delivered_next = '0;
                    start_next     = '0;
                    goal_next      = '0;
                end
            end
            wcs_pkg::REQ_MANUAL:
            begin
                if (active_reg)
                begin
                    out_next.stop_event        = 1'b1;
                    out_next.stop_reason       = wcs_pkg::REASON_USER;
                    out_next.stopped_cycle     = cycle_reg;
                    out_next.stopped_volume_ml = vol_acc;
                    out_next.run_seconds       = elapsed[15:0];
                end
                active_next    = 1'b1;
                paused_next    = 1'b0;
                cycle_next     = wcs_pkg::MANUAL_CYCLE;
                delivered_next = '0;
                start_next     = in_reg.now_seconds;
                goal_next      = in_reg.manual_target_ml;
            end
            wcs_pkg::REQ_STOP:
            begin
                if (active_reg)
                begin
                    out_next.stop_event        = 1'b1;
                    out_next.stop_reason       = wcs_pkg::REASON_USER;
                    out_next.stopped_cycle     = cycle_reg;
                    out_next.stopped_volume_ml = vol_acc;
                    out_next.run_seconds       = elapsed[15:0];
                    active_next    = 1'b0;
                    paused_next    = 1'b0;
                    cycle_next     = '0;
                    delivered_next = '0;
                    start_next     = '0;
                    goal_next      = '0;
                end
            end
            wcs_pkg::REQ_PAUSE:
            begin
                if (active_reg)
                begin
                    paused_next = 1'b1;
                end
            end
            wcs_pkg::REQ_RESUME:
            begin
                if (active_reg)
                begin
                    paused_next = 1'b0;
                end
            end
            default:
            begin
                // unknown request: flow accounting only
            end
        endcase

        out_next.valve_on      = active_next && !paused_next;
        out_next.run_active    = active_next;
        out_next.run_paused    = active_next && paused_next;
        out_next.current_cycle = active_next ? cycle_next : '0;
    end

    // Handshake flags and run state clear on reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg    <= 1'b0;
            out_vld_reg   <= 1'b0;
            active_reg    <= 1'b0;
            paused_reg    <= 1'b0;
            cycle_reg     <= '0;
            delivered_reg <= '0;
            start_reg     <= '0;
            goal_reg      <= '0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (fire)
            begin
                active_reg    <= active_next;
                paused_reg    <= paused_next;
                cycle_reg     <= cycle_next;
                delivered_reg <= delivered_next;
                start_reg     <= start_next;
                goal_reg      <= goal_next;
            end
        end
    end

    // Payload registers: input loads on take, result loads on fire; both hold otherwise
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_reg <= in_data;
        end
        if (fire)
        begin
            out_reg <= out_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_pause_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
        paused_reg |-> active_reg)
        else $error("paused flag set with no active run");

    a_cycle_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg && (cycle_reg != wcs_pkg::MANUAL_CYCLE)) |-> ({1'b0, cycle_reg} < SLOT_LIMIT))
        else $error("active run on a slot outside the configured range");

    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_vld_reg)
        else $error("processed item produced no result");

    a_idle_state_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> ((cycle_reg == '0) && (delivered_reg == '0) && (goal_reg == '0)))
        else $error("idle scheduler holds stale run state");

endmodule

// ===== tb/wcs_checker.sv =====
module wcs_checker #(
    parameter int unsigned NUM_SLOTS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  wcs_pkg::in_t                      in_data,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  wcs_pkg::out_t                     out_data,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [wcs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wcs_pkg::CFG_W-1:0]         cfg_data,
    output int                                mismatches,
    output int                                outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow of the slot registers and of the run state
    wcs_pkg::slot_t               slot_copy [8];
    logic                         run_on;
    logic                         run_held;
    logic [wcs_pkg::CYCLE_W-1:0]  run_cycle;
    logic [wcs_pkg::VOL_W-1:0]    run_volume;
    logic [wcs_pkg::SECS_W-1:0]   run_start;
    logic [wcs_pkg::VOL_W-1:0]    run_goal;

    wcs_pkg::out_t                reports_due [$];
    int                           mismatch_count = 0;
    int                           due_count = 0;
    int                           report_index = 0;

    assign mismatches  = mismatch_count;
    assign outstanding = due_count;

    function automatic void open_run(input logic [wcs_pkg::CYCLE_W-1:0] cycle,
                                     input logic [wcs_pkg::SECS_W-1:0] now,
                                     input logic [wcs_pkg::VOL_W-1:0] goal);
        run_on     = 1'b1;
        run_held   = 1'b0;
        run_cycle  = cycle;
        run_volume = '0;
        run_start  = now;
        run_goal   = goal;
    endfunction

    function automatic void close_run(input logic reason,
                                      input logic [wcs_pkg::SECS_W-1:0] now,
                                      inout wcs_pkg::out_t rpt);
        logic [wcs_pkg::SECS_W-1:0] span;
        span                  = now - run_start;
        rpt.stop_event        = 1'b1;
        rpt.stop_reason       = reason;
        rpt.stopped_cycle     = run_cycle;
        rpt.stopped_volume_ml = run_volume;
        rpt.run_seconds       = span[15:0];
        run_on     = 1'b0;
        run_held   = 1'b0;
        run_cycle  = '0;
        run_volume = '0;
        run_start  = '0;
        run_goal   = '0;
    endfunction

    // Advance the shadow state by one item and return the report it should produce
    function automatic wcs_pkg::out_t predict_report(input wcs_pkg::in_t item);
        wcs_pkg::out_t             rpt;
        logic [wcs_pkg::VOL_W:0]   sum;
        logic                      started;
        logic                      done;
        wcs_pkg::slot_t            s;
        rpt     = '0;
        started = 1'b0;
        done    = 1'b0;

        // Metered flow counts only while the valve is open before this item
        if (run_on && !run_held)
        begin
            sum        = {1'b0, run_volume} + (wcs_pkg::VOL_W+1)'(item.flow_delta_ml);
            run_volume = sum[wcs_pkg::VOL_W] ? wcs_pkg::VOL_MAX : sum[wcs_pkg::VOL_W-1:0];
        end

        case (item.req_type)
            wcs_pkg::REQ_TICK:
            begin
                if (!run_on && item.clock_valid)
                begin
                    for (int i = 0; i < NUM_SLOTS; i++)
                    begin
                        if (!started && slot_copy[i].enable &&
                            slot_copy[i].start_minute == item.minute_of_day)
                        begin
                            open_run(i[wcs_pkg::CYCLE_W-1:0], item.now_seconds, '0);
                            started = 1'b1;
                        end
                    end
                end
                if (run_on && !run_held)
                begin
                    if (run_cycle == wcs_pkg::MANUAL_CYCLE)
                    begin
                        done = (run_goal != '0) && (run_volume >= run_goal);
                    end
                    else if (32'(run_cycle) < NUM_SLOTS)
                    begin
                        s = slot_copy[run_cycle];
                        case (s.mode)
                            wcs_pkg::MODE_VOLUME: done = run_volume >= s.target_ml;
                            wcs_pkg::MODE_END:    done = item.minute_of_day >= s.end_minute;
                            wcs_pkg::MODE_EITHER: done = (run_volume >= s.target_ml) ||
                                                  (item.minute_of_day >= s.end_minute);
                            default:              done = 1'b0;
                        endcase
                    end
                    if (done)
                    begin
                        close_run(wcs_pkg::REASON_COMPLETED, item.now_seconds, rpt);
                    end
                end
            end
            wcs_pkg::REQ_MANUAL:
            begin
                if (run_on)
                begin
                    close_run(wcs_pkg::REASON_USER, item.now_seconds, rpt);
                end
                open_run(wcs_pkg::MANUAL_CYCLE, item.now_seconds, item.manual_target_ml);
            end
            wcs_pkg::REQ_STOP:
            begin
                if (run_on)
                begin
                    close_run(wcs_pkg::REASON_USER, item.now_seconds, rpt);
                end
            end
            wcs_pkg::REQ_PAUSE:
            begin
                if (run_on && !run_held)
                begin
                    run_held = 1'b1;
                end
            end
            wcs_pkg::REQ_RESUME:
            begin
                if (run_on && run_held)
                begin
                    run_held = 1'b0;
                end
            end
            default: ;
        endcase

        rpt.valve_on      = run_on && !run_held;
        rpt.run_active    = run_on;
        rpt.run_paused    = run_on && run_held;
        rpt.current_cycle = run_on ? run_cycle : '0;
        return rpt;
    endfunction

    function automatic string describe(input wcs_pkg::out_t r);
        return $sformatf({"valve %b active %b paused %b cycle %0d | stop %b reason %b ",
                          "slot %0d volume %0d secs %0d"},
                         r.valve_on, r.run_active, r.run_paused, r.current_cycle,
                         r.stop_event, r.stop_reason, r.stopped_cycle,
                         r.stopped_volume_ml, r.run_seconds);
    endfunction

    function automatic void check_report(input wcs_pkg::out_t want,
                                         input wcs_pkg::out_t got);
        logic bad;
        bad = (got.valve_on          !== want.valve_on)          ||
              (got.run_active        !== want.run_active)        ||
              (got.run_paused        !== want.run_paused)        ||
              (got.current_cycle     !== want.current_cycle)     ||
              (got.stop_event        !== want.stop_event)        ||
              (got.stop_reason       !== want.stop_reason)       ||
              (got.stopped_cycle     !== want.stopped_cycle)     ||
              (got.stopped_volume_ml !== want.stopped_volume_ml) ||
              (got.run_seconds       !== want.run_seconds);
        if (bad)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
            begin
                $display("[%0t] report %0d mismatch", $realtime, report_index);
                $display("    expected: %s", describe(want));
                $display("    actual:   %s", describe(got));
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (slot_copy[i])
            begin
                slot_copy[i] = '0;
            end
            run_on     = 1'b0;
            run_held   = 1'b0;
            run_cycle  = '0;
            run_volume = '0;
            run_start  = '0;
            run_goal   = '0;
            reports_due.delete();
            due_count  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                slot_copy[cfg_index] = cfg_data;
            end
            if (in_valid && !in_stall)
            begin
                reports_due.push_back(predict_report(in_data));
            end
            if (out_valid && !out_stall)
            begin
                if (reports_due.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("[%0t] report with nothing outstanding: %s",
                                 $realtime, describe(out_data));
                    end
                end
                else
                begin
                    check_report(reports_due.pop_front(), out_data);
                end
                report_index++;
            end
            due_count = reports_due.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NUM_SLOTS    = 8;
    localparam int          RANDOM_ITEMS = 120;

    // Request codes the block ignores apart from flow accounting
    localparam logic [2:0]  REQ_SPARE_LO = 3'd5;
    localparam logic [2:0]  REQ_SPARE_HI = 3'd7;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    wcs_pkg::in_t                    in_data;
    logic                            out_valid;
    logic                            out_stall;
    wcs_pkg::out_t                   out_data;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [wcs_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [wcs_pkg::CFG_W-1:0]       cfg_data;

    int                              mismatches;
    int                              outstanding;

    // Idle switches, redrawn per phase so some stretches run back to back
    bit                              in_gaps_on;
    bit                              out_gaps_on;

    // Running epoch seconds shared by every item
    logic [wcs_pkg::SECS_W-1:0]      epoch;
    wcs_pkg::slot_t                  slot_plan [NUM_SLOTS];

    watering_cycle_scheduler #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    wcs_checker #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hand one item to the block. Called and returns at a falling edge.
    // Valid stays high across back-to-back items; it drops only for a gap.
    task automatic send_item(input wcs_pkg::in_t item);
        int gap;
        gap = in_gaps_on ? $urandom_range(0, 9) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data  <= item;
        in_valid <= 1'b1;
        // hold the item until a rising edge sees stall low
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // Build an item stamped with an advancing epoch and send it
    task automatic issue(input logic [2:0] req, input logic clock_ok,
                         input logic [wcs_pkg::MINUTE_W-1:0] minute,
                         input logic [15:0] flow,
                         input logic [wcs_pkg::VOL_W-1:0] goal);
        wcs_pkg::in_t item;
        epoch                 = epoch + $urandom_range(1, 90);
        item.req_type         = req;
        item.clock_valid      = clock_ok;
        item.minute_of_day    = minute;
        item.now_seconds      = epoch;
        item.flow_delta_ml    = flow;
        item.manual_target_ml = goal;
        send_item(item);
    endtask

    // Write all eight slot registers from slot_plan; block must be idle
    task automatic program_slots();
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            cfg_index <= i[wcs_pkg::CFG_IDX_W-1:0];
            cfg_data  <= slot_plan[i];
            cfg_valid <= 1'b1;
            do @(posedge clk); while (!cfg_ready);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // Drop valid and wait until every report has come back, plus a margin
    // for the two-stage pipeline.
    task automatic drain();
        in_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    function automatic wcs_pkg::slot_t slot_word(input logic en, input logic [1:0] mode,
                                        input logic [wcs_pkg::MINUTE_W-1:0] start_min,
                                        input logic [wcs_pkg::MINUTE_W-1:0] end_min,
                                        input logic [wcs_pkg::VOL_W-1:0] goal);
        wcs_pkg::slot_t s;
        s.enable       = en;
        s.mode         = mode;
        s.start_minute = start_min;
        s.end_minute   = end_min;
        s.target_ml    = goal;
        return s;
    endfunction

    // Slots clustered around the minute window a phase will walk through,
    // so that scheduled starts actually fire.
    function automatic wcs_pkg::slot_t random_slot(input logic [wcs_pkg::MINUTE_W-1:0] base);
        wcs_pkg::slot_t s;
        s.enable       = ($urandom_range(0, 6) != 0);
        s.mode         = 2'($urandom_range(0, 3));
        s.start_minute = base + wcs_pkg::MINUTE_W'($urandom_range(0, 20));
        s.end_minute   = s.start_minute + wcs_pkg::MINUTE_W'($urandom_range(0, 15));
        s.target_ml    = ($urandom_range(0, 9) == 0) ? wcs_pkg::VOL_W'($urandom)
                                                     : wcs_pkg::VOL_W'($urandom_range(0, 3000));
        return s;
    endfunction

    // One random item. Mostly ticks walking the minute window forward, with
    // commands mixed in and a little noise: spare codes and fully random items.
    task automatic random_item(inout logic [wcs_pkg::MINUTE_W-1:0] cursor);
        int                        pick;
        logic [15:0]               flow;
        logic [wcs_pkg::VOL_W-1:0] goal;
        logic [95:0]               raw;
        wcs_pkg::in_t              item;
        pick = $urandom_range(0, 99);
        flow = ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
        case ($urandom_range(0, 2))
            0:       goal = '0;
            1:       goal = wcs_pkg::VOL_W'($urandom_range(1, 800));
            default: goal = wcs_pkg::VOL_W'($urandom);
        endcase
        if (pick < 68)
        begin
            if ($urandom_range(0, 1) != 0)
            begin
                cursor = cursor + wcs_pkg::MINUTE_W'(1);
            end
            issue(wcs_pkg::REQ_TICK, $urandom_range(0, 9) != 0, cursor, flow,
                  wcs_pkg::VOL_W'($urandom));
        end
        else if (pick < 76)
        begin
            issue(wcs_pkg::REQ_MANUAL, 1'($urandom_range(0, 1)), cursor, flow, goal);
        end
        else if (pick < 83)
        begin
            issue(wcs_pkg::REQ_STOP, 1'($urandom_range(0, 1)), cursor, flow, goal);
        end
        else if (pick < 89)
        begin
            issue(wcs_pkg::REQ_PAUSE, 1'($urandom_range(0, 1)), cursor, flow, goal);
        end
        else if (pick < 95)
        begin
            issue(wcs_pkg::REQ_RESUME, 1'($urandom_range(0, 1)), cursor, flow, goal);
        end
        else if (pick < 98)
        begin
            issue(3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI)), 1'($urandom_range(0, 1)),
                  wcs_pkg::MINUTE_W'($urandom), 16'($urandom), goal);
        end
        else
        begin
            // every field random, the epoch jumps with it
            raw   = {$urandom, $urandom, $urandom};
            item  = raw[$bits(wcs_pkg::in_t)-1:0];
            epoch = item.now_seconds;
            send_item(item);
        end
    endtask

    // Receiver: per report, stall a random number of cycles, then take it
    initial
    begin
        int hold;
        out_stall = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            hold = out_gaps_on ? $urandom_range(0, 9) : 0;
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    initial
    begin
        logic [wcs_pkg::MINUTE_W-1:0] cursor;
        logic [wcs_pkg::MINUTE_W-1:0] base;
        logic [63:0]                  raw;
        int                           phase;
        int                           len;
        int                           random_sent;
        int                           guard;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_gaps_on  = 1'b1;
        out_gaps_on = 1'b1;
        epoch       = 32'd1000;
        random_sent = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // ---------------- directed part ----------------
        // Slots 0 and 1 share a start minute so the lower one must win;
        // slot 5 has a zero target and finishes on the tick that starts it;
        // slot 6 is disabled; slot 7 starts at a minute past the end of day.
        slot_plan[0] = slot_word(1'b1, wcs_pkg::MODE_VOLUME,  11'd5,    11'd20,   24'd100);
        slot_plan[1] = slot_word(1'b1, wcs_pkg::MODE_VOLUME,  11'd5,    11'd20,   24'd0);
        slot_plan[2] = slot_word(1'b1, wcs_pkg::MODE_END,     11'd30,   11'd32,   24'd0);
        slot_plan[3] = slot_word(1'b1, wcs_pkg::MODE_EITHER,  11'd40,   11'd2047, 24'd50);
        slot_plan[4] = slot_word(1'b1, wcs_pkg::MODE_NO_AUTO, 11'd1439, 11'd0,    24'd0);
        slot_plan[5] = slot_word(1'b1, wcs_pkg::MODE_VOLUME,  11'd50,   11'd60,   24'd0);
        slot_plan[6] = slot_word(1'b0, wcs_pkg::MODE_VOLUME,  11'd60,   11'd70,   24'd0);
        slot_plan[7] = slot_word(1'b1, wcs_pkg::MODE_EITHER,  11'd2047, 11'd2047,
                                 wcs_pkg::VOL_MAX);
        program_slots();

        issue(wcs_pkg::REQ_TICK,   1'b0, 11'd5,  16'd0,   24'd0);  // clock not set: no start
        issue(wcs_pkg::REQ_TICK,   1'b1, 11'd5,  16'd7,   24'd0);  // slot 0 starts, no delta
        issue(wcs_pkg::REQ_TICK,   1'b1, 11'd6,  16'd60,  24'd0);
        issue(wcs_pkg::REQ_PAUSE,  1'b1, 11'd6,  16'd0,   24'd0);
        issue(wcs_pkg::REQ_PAUSE,  1'b1, 11'd6,  16'd0,   24'd0);  // already paused: ignore
        issue(wcs_pkg::REQ_TICK,   1'b1, 11'd7,  16'd500, 24'd0);  // paused: no flow
        issue(wcs_pkg::REQ_RESUME, 1'b1, 11'd7,  16'd33,  24'd0);  // resume: no flow
        issue(wcs_pkg::REQ_TICK,   1'b1, 11'd8,  16'd40,  24'd0);  // reaches the 100 mL target
        issue(wcs_pkg::REQ_RESUME, 1'b1, 11'd8,  16'd0,   24'd0);  // idle: ignore
        issue(wcs_pkg::REQ_STOP,   1'b1, 11'd8,  16'd0,   24'd0);  // idle: ignore
        issue(wcs_pkg::REQ_TICK,   1'b1, 11'd50, 16'd0,   24'd0);  // start and finish at once
        issue(wcs_pkg::REQ_TICK,   1'b1, 11'd30, 16'd0,   24'd0);  // slot 2 by end minute
        issue(wcs_pkg::REQ_TICK,   1'b1, 11'd31, 16'd10,  24'd0);
        issue(wcs_pkg::REQ_TICK,   1'b1, 11'd32, 16'd10,  24'd0);
        issue(wcs_pkg::REQ_TICK,   1'b1, 11'd30, 16'd0,   24'd0);
        epoch = 32'hFFFF_FFE0;                                     // duration wraps the epoch
        issue(wcs_pkg::REQ_MANUAL, 1'b1, 11'd30, 16'd9,   24'd0);  // preempt slot 2
        issue(wcs_pkg::REQ_TICK,   1'b1, 11'd31, 16'hFFFF, 24'd0);
        issue(wcs_pkg::REQ_STOP,   1'b1, 11'd31, 16'hFFFF, 24'd0);
        issue(wcs_pkg::REQ_TICK,   1'b1, 11'd60, 16'd0,   24'd0);  // disabled slot stays idle
        issue(wcs_pkg::REQ_TICK,   1'b1, 11'd1439, 16'd0, 24'd0);  // slot 4 never ends itself
        issue(wcs_pkg::REQ_TICK,   1'b1, 11'd1439, 16'hFFFF, 24'd0);
        issue(REQ_SPARE_LO, 1'b1, 11'd0, 16'd100, 24'd0);          // spare code, flow counts
        issue(REQ_SPARE_HI, 1'b0, 11'd0, 16'd1,   24'd0);
        issue(wcs_pkg::REQ_STOP,   1'b1, 11'd0,  16'd0,   24'd0);
        issue(wcs_pkg::REQ_TICK,   1'b1, 11'd2047, 16'd0, 24'd0);  // slot 7 starts and ends
        issue(wcs_pkg::REQ_MANUAL, 1'b0, 11'd0,  16'd0,   24'd10); // manual run with a target
        issue(wcs_pkg::REQ_TICK,   1'b0, 11'd0,  16'd9,   24'd0);
        issue(wcs_pkg::REQ_TICK,   1'b0, 11'd0,  16'd1,   24'd0);

        // Saturate the volume: a manual run aimed at the ceiling must clamp
        // there and complete; keep both sides busy so it goes quickly.
        drain();
        in_gaps_on  = 1'b0;
        out_gaps_on = 1'b0;
        issue(wcs_pkg::REQ_MANUAL, 1'b0, 11'd0, 16'hFFFF, wcs_pkg::VOL_MAX);
        repeat (260) issue(wcs_pkg::REQ_TICK, 1'b0, 11'd0, 16'hFFFF, 24'd0);

        // ---------------- random phases ----------------
        // Each phase reprograms every slot while the pipeline is empty (a run
        // may still be active, which covers slot edits mid-run), then walks a
        // window of minutes. The first two phases use the register extremes, the third raw random words.
        phase = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            drain();
            in_gaps_on  = ($urandom_range(0, 3) != 0);
            out_gaps_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 3))
                0:       base = '0;
                1:       base = wcs_pkg::MINUTE_W'($urandom_range(0, 1439));
                2:       base = 11'd1420;
                default: base = 11'd2030;
            endcase
            if (phase == 1)
            begin
                base = 11'd2040;
            end
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                case (phase)
                    0: slot_plan[i] = '0;
                    1: slot_plan[i] = '1;
                    2:
                    begin
                        raw          = {$urandom, $urandom};
                        slot_plan[i] = raw[wcs_pkg::CFG_W-1:0];
                    end
                    default: slot_plan[i] = random_slot(base);
                endcase
            end
            program_slots();
            cursor = base;
            len    = $urandom_range(12, 24);
            repeat (len)
            begin
                random_item(cursor);
                random_sent++;
            end
            phase++;
        end

        // Let the last reports come back, with a bound
        in_valid <= 1'b0;
        guard = 0;
        while (outstanding != 0 && guard < 5000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (5) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== watering_cycle_scheduler.f =====
design/wcs_pkg.sv
design/wcs_slot_eval.sv
design/watering_cycle_scheduler.sv
tb/wcs_checker.sv
tb/tb_top.sv
